// ===== src/kesd_pkg.sv =====
// shared types, command codes and segment patterns for the keypad entry display
`timescale 1ns / 1ps

package kesd_pkg;

    // command codes
    localparam logic [1:0] CmdScan  = 2'd0;
    localparam logic [1:0] CmdKey   = 2'd1;
    localparam logic [1:0] CmdClear = 2'd2;

    // number of decimal digits held in the entry value
    localparam int ValueDigits = 4;

    // key codes at or above this are operator keys
    localparam logic [3:0] FirstOperatorKey = 4'd10;

    localparam logic [7:0] SegmentsOff = 8'hFF;
    localparam logic [3:0] EnablesOff  = 4'hF;

    typedef logic [3:0] bcd_digit_t;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] key_code;
    } kesd_in_t;

    typedef struct packed {
        logic [7:0]  segments;
        logic [3:0]  digit_enables_n;
        logic        entry_pulse;
        logic [13:0] shown_value;
    } kesd_out_t;

    // entry value as bcd digits plus the held display drive
    typedef struct packed {
        bcd_digit_t [ValueDigits-1:0] bcd;
        logic [7:0]                   segs;
        logic [3:0]                   ens;
    } kesd_disp_t;

    // seven-segment pattern, bit0 is segment a, lit segment is 1
    function automatic logic [7:0] seg_pattern(input bcd_digit_t digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h3F;
        endcase
        return pat;
    endfunction

endpackage

// ===== src/kesd_update.sv =====
// next-state and result logic for one item of the keypad entry display
`timescale 1ns / 1ps

module kesd_update
    import kesd_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  kesd_in_t                                    item,
    input  kesd_disp_t                                  disp,
    input  logic [((DIGITS > 1) ? $clog2(DIGITS) : 1)-1:0] pos,
    output kesd_disp_t                                  disp_next,
    output logic [((DIGITS > 1) ? $clog2(DIGITS) : 1)-1:0] pos_next,
    output kesd_out_t                                   result
);

    localparam int PosW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    bcd_digit_t scan_digit;
    logic [3:0] scan_ens;
    logic       pulse;

    // digit at the scan position, zero past the stored digits
    always_comb
    begin
        scan_digit = '0;
        scan_ens   = EnablesOff;
        for (int i = 0; i < ValueDigits; i++)
        begin
            if (32'(pos) == i)
            begin
                scan_digit  = disp.bcd[i];
                scan_ens[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        disp_next = disp;
        pos_next  = pos;
        pulse     = 1'b0;
        case (item.command)
            CmdScan:
            begin
                disp_next.segs = seg_pattern(scan_digit);
                disp_next.ens  = scan_ens;
                if (pos == PosW'(DIGITS - 1))
                    pos_next = '0;
                else
                    pos_next = pos + PosW'(1);
            end
            CmdKey:
            begin
                pulse = 1'b1;
                if (item.key_code < FirstOperatorKey)
                    disp_next.bcd = {disp.bcd[2:0], item.key_code};
                else
                    disp_next.bcd = {disp.bcd[1:0], 4'd1,
                                     4'(item.key_code - FirstOperatorKey)};
            end
            CmdClear:
            begin
                disp_next.bcd = '0;
            end
            default:
            begin
                disp_next = disp;
            end
        endcase
    end

    always_comb
    begin
        result.segments        = disp_next.segs;
        result.digit_enables_n = disp_next.ens;
        result.entry_pulse     = pulse;
        result.shown_value     = 14'(disp_next.bcd[3]) * 14'd1000
                               + 14'(disp_next.bcd[2]) * 14'd100
                               + 14'(disp_next.bcd[1]) * 14'd10
                               + 14'(disp_next.bcd[0]);
    end

endmodule

// ===== src/keypad_entry_segment_display_top.sv =====
// top level of the keypad entry value with multiplexed seven-segment drive
`timescale 1ns / 1ps
// an accepted item passes the item register and then the result register on its way out
// throughput: one item per cycle, both sides may stall independently
// the value is kept as four bcd digits so no divider is needed for the scan
// reset: value 0, scan position 0, segments all ones, enables all off
// reset also empties the item and result registers

module keypad_entry_segment_display_top
    import kesd_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  kesd_in_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output kesd_out_t result
);

    localparam int PosW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    // item stage
    logic       item_valid_reg;
    kesd_in_t   item_reg;

    // result stage
    logic       result_valid_reg;
    kesd_out_t  result_reg;
    kesd_out_t  result_next;

    // block state: bcd value, held display drive, scan position
    kesd_disp_t      disp_reg;
    kesd_disp_t      disp_next;
    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;

    logic result_load;
    logic advance;

    // result register frees up when empty or being taken
    assign result_load = !result_valid_reg || result_ready;
    // item moves on into the result register, state updates with it
    assign advance     = item_valid_reg && result_load;
    assign item_ready  = !item_valid_reg || result_load;

    kesd_update #(
        .DIGITS (DIGITS)
    ) u_update (
        .item      (item_reg),
        .disp      (disp_reg),
        .pos       (pos_reg),
        .disp_next (disp_next),
        .pos_next  (pos_next),
        .result    (result_next)
    );

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            disp_reg.bcd     <= '0;
            disp_reg.segs    <= SegmentsOff;
            disp_reg.ens     <= EnablesOff;
            pos_reg          <= '0;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= item_valid;
            if (result_load)
                result_valid_reg <= item_valid_reg;
            if (advance)
            begin
                disp_reg <= disp_next;
                pos_reg  <= pos_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== tb/keypad_entry_segment_display_top_tb.sv =====
// self-checking testbench for the keypad entry value and multiplexed seven-segment scan
`timescale 1ns / 1ps

module keypad_entry_segment_display_top_tb;
    import kesd_pkg::*;

    // scan width of the instance under test
    localparam int DISPLAY_DIGITS = 4;
    // the one command code the block ignores
    localparam logic [1:0] CmdUnused = 2'd3;
    // random items after the directed part
    localparam int RANDOM_ITEMS = 2000;
    // no new idle bursts on either side once this few items are left to send
    localparam int CALM_TAIL = 150;

    // one queued item, optionally held back until the block has drained
    typedef struct {
        kesd_in_t cmd;
        bit       drain_first;
    } pending_cmd_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    kesd_in_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    kesd_out_t result;

    pending_cmd_t pending_cmds[$];
    kesd_out_t    expected_display[$];

    // predicted display state
    int         model_value;
    int         model_pos;
    logic [7:0] model_segs = SegmentsOff;
    logic [3:0] model_ens  = EnablesOff;

    // idle burst counters for the two sides
    int send_gap;
    int recv_stall;

    bit drain_next;
    int queued_count;
    int errors_seen;
    int results_checked;
    int n_keys;
    int n_scans;
    int n_clears;
    int n_ignored;

    keypad_entry_segment_display_top #(
        .DIGITS(DISPLAY_DIGITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // glyph of one decimal digit, bit0 is segment a
    function automatic logic [7:0] digit_glyph(input int digit);
        logic [7:0] glyph;
        case (digit)
            1:       glyph = 8'h06;
            2:       glyph = 8'h5B;
            3:       glyph = 8'h4F;
            4:       glyph = 8'h66;
            5:       glyph = 8'h6D;
            6:       glyph = 8'h7D;
            7:       glyph = 8'h07;
            8:       glyph = 8'h7F;
            9:       glyph = 8'h6F;
            default: glyph = 8'h3F;
        endcase
        return glyph;
    endfunction

    // advance the predicted display by one accepted item and queue what it shows
    task automatic step_display_model(input kesd_in_t cmd);
        kesd_out_t want;
        int        scale;
        begin
            want.entry_pulse = 1'b0;
            case (cmd.command)
                CmdScan:
                begin
                    if (model_pos < ValueDigits)
                    begin
                        scale = 1;
                        repeat (model_pos) scale = scale * 10;
                        model_segs = digit_glyph((model_value / scale) % 10);
                        model_ens  = EnablesOff & ~(4'b0001 << model_pos);
                    end
                    else
                    begin
                        // positions past the fourth show zero with no enable
                        model_segs = digit_glyph(0);
                        model_ens  = EnablesOff;
                    end
                    model_pos = (model_pos + 1) % DISPLAY_DIGITS;
                    n_scans++;
                end
                CmdKey:
                begin
                    if (cmd.key_code < FirstOperatorKey)
                        model_value = (model_value % 1000) * 10 + int'(cmd.key_code);
                    else
                        model_value = (model_value % 100) * 100 + int'(cmd.key_code);
                    want.entry_pulse = 1'b1;
                    n_keys++;
                end
                CmdClear:
                begin
                    model_value = 0;
                    n_clears++;
                end
                default:
                    n_ignored++;
            endcase
            want.segments        = model_segs;
            want.digit_enables_n = model_ens;
            want.shown_value     = 14'(model_value);
            expected_display.push_back(want);
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors_seen++;
        end
    endfunction

    task automatic queue_cmd(input logic [1:0] command, input logic [3:0] key);
        pending_cmd_t entry;
        begin
            entry.cmd.command  = command;
            entry.cmd.key_code = key;
            entry.drain_first  = drain_next;
            drain_next = 1'b0;
            pending_cmds.push_back(entry);
            queued_count++;
        end
    endtask

    // driver: one item per handshake, random gaps except near the end,
    // and items marked drain_first wait for every outstanding result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                step_display_model(item);
            // valid holds until accepted, so only pick a new item after a handshake
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
                begin
                    // start an idle burst here, its random remainder kept in send_gap
                    send_gap = $urandom_range(0, 7);
                    item_valid <= 1'b0;
                end
                else if (pending_cmds.size() == 0)
                    item_valid <= 1'b0;
                else if (pending_cmds[0].drain_first && expected_display.size() != 0)
                    item_valid <= 1'b0;
                else
                begin
                    item       <= pending_cmds[0].cmd;
                    item_valid <= 1'b1;
                    void'(pending_cmds.pop_front());
                end
            end
        end
    end

    // monitor: checks each result against the oldest prediction, stalls at random
    always @(posedge clk)
    begin : monitor
        kesd_out_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_display.size() == 0)
                begin
                    $error("result with no item outstanding: %p", result);
                    errors_seen++;
                end
                else
                begin
                    want = expected_display.pop_front();
                    check_field("segments", 16'(want.segments), 16'(result.segments));
                    check_field("digit_enables_n", 16'(want.digit_enables_n),
                                16'(result.digit_enables_n));
                    check_field("entry_pulse", 16'(want.entry_pulse), 16'(result.entry_pulse));
                    check_field("shown_value", 16'(want.shown_value), 16'(result.shown_value));
                    results_checked++;
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                result_ready <= 1'b0;
            end
            else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(0, 7);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin : stimulus
        int         burst;
        int         k;
        logic [3:0] key;

        // reset state is reported by an ignored command
        queue_cmd(CmdUnused, 4'hF);
        // scan an all-zero value past the wrap of the position
        repeat (5) queue_cmd(CmdScan, 4'h0);
        // largest value, then a digit key on a full value
        repeat (5) queue_cmd(CmdKey, 4'd9);
        // operator keys at both ends of their range
        queue_cmd(CmdKey, 4'd15);
        queue_cmd(CmdKey, 4'd10);
        repeat (4) queue_cmd(CmdScan, 4'hA);
        // clear leaves the held drive alone, key field is don't-care
        queue_cmd(CmdClear, 4'hF);
        queue_cmd(CmdUnused, 4'h0);
        queue_cmd(CmdKey, 4'd0);
        queue_cmd(CmdKey, 4'd7);
        queue_cmd(CmdKey, 4'd12);
        repeat (2) queue_cmd(CmdScan, 4'h5);

        // random part, mostly numbers typed in and then scanned out
        drain_next = 1'b1;
        while (queued_count < RANDOM_ITEMS + 25)
        begin
            if ($urandom_range(0, 149) == 0)
                drain_next = 1'b1;
            burst = $urandom_range(0, 3);
            case (burst)
                0, 1:
                begin
                    k = $urandom_range(1, 5);
                    repeat (k)
                    begin
                        if ($urandom_range(0, 5) == 0)
                            key = 4'($urandom_range(10, 15));
                        else
                            key = 4'($urandom_range(0, 9));
                        queue_cmd(CmdKey, key);
                    end
                    k = $urandom_range(4, 9);
                    repeat (k) queue_cmd(CmdScan, 4'($urandom));
                end
                2:
                begin
                    // noise, any command including the ignored one
                    k = $urandom_range(1, 6);
                    repeat (k) queue_cmd(2'($urandom_range(0, 3)), 4'($urandom));
                end
                default:
                begin
                    queue_cmd(CmdClear, 4'($urandom));
                    k = $urandom_range(1, 4);
                    repeat (k) queue_cmd(CmdScan, 4'($urandom));
                end
            endcase
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // all items out, one result back for every item, then a wait for strays
        while (pending_cmds.size() != 0 || item_valid) @(posedge clk);
        while (results_checked < queued_count || expected_display.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d results: %0d key presses, %0d scan ticks, %0d clears",
                 results_checked, n_keys, n_scans, n_clears);
        $display("%0d ignored commands, %0d mismatches", n_ignored, errors_seen);
        if (errors_seen == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
src/kesd_pkg.sv
src/kesd_update.sv
src/keypad_entry_segment_display_top.sv
tb/keypad_entry_segment_display_top_tb.sv
